// File: rtl/tibs_pkg.sv
// ----------------------------------------------------------------------------
// Tape image block splitter package
// Shared constants, block type codes, record types and the type decoder.
// ----------------------------------------------------------------------------
package tibs_pkg;

  localparam int OFFSET_WIDTH_DEF = 40;
  localparam int INDEX_WIDTH_DEF  = 32;
  localparam int OFFSET_OUT_W     = 40;
  localparam int LENGTH_OUT_W     = 33;
  localparam int NUMBER_OUT_W     = 32;
  localparam int PAYLOAD_W        = 34;
  localparam int FIXED_W          = 5;
  localparam int QUEUE_DEPTH      = 2;
  localparam logic [7:0] START_OFFSET_RST = 8'h0A;

  localparam logic [7:0] ID_STD_SPEED   = 8'h10;
  localparam logic [7:0] ID_TURBO       = 8'h11;
  localparam logic [7:0] ID_PURE_TONE   = 8'h12;
  localparam logic [7:0] ID_PULSE_SEQ   = 8'h13;
  localparam logic [7:0] ID_PURE_DATA   = 8'h14;
  localparam logic [7:0] ID_DIRECT_REC  = 8'h15;
  localparam logic [7:0] ID_CSW         = 8'h18;
  localparam logic [7:0] ID_GENERALIZED = 8'h19;
  localparam logic [7:0] ID_PAUSE       = 8'h20;
  localparam logic [7:0] ID_GROUP_START = 8'h21;
  localparam logic [7:0] ID_GROUP_END   = 8'h22;
  localparam logic [7:0] ID_JUMP        = 8'h23;
  localparam logic [7:0] ID_LOOP_START  = 8'h24;
  localparam logic [7:0] ID_LOOP_END    = 8'h25;
  localparam logic [7:0] ID_CALL_SEQ    = 8'h26;
  localparam logic [7:0] ID_RETURN      = 8'h27;
  localparam logic [7:0] ID_SELECT      = 8'h28;
  localparam logic [7:0] ID_STOP_48K    = 8'h2A;
  localparam logic [7:0] ID_SET_LEVEL   = 8'h2B;
  localparam logic [7:0] ID_TEXT        = 8'h30;
  localparam logic [7:0] ID_MESSAGE     = 8'h31;
  localparam logic [7:0] ID_ARCHIVE     = 8'h32;
  localparam logic [7:0] ID_HARDWARE    = 8'h33;
  localparam logic [7:0] ID_CUSTOM      = 8'h35;
  localparam logic [7:0] ID_GLUE        = 8'h5A;

  localparam logic [1:0] MULT_X1 = 2'd1;
  localparam logic [1:0] MULT_X2 = 2'd2;
  localparam logic [1:0] MULT_X3 = 2'd3;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_ID,
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [3:0] hdr;
    logic [2:0] lenw;
    logic [1:0] mult;
    logic       known;
  } kind_t;

  typedef struct packed {
    logic [7:0]              block_id;
    logic [OFFSET_OUT_W-1:0] block_offset;
    logic [PAYLOAD_W-1:0]    payload;
    logic [FIXED_W-1:0]      fixed;
    logic                    known;
    logic [NUMBER_OUT_W-1:0] block_number;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic valid;
    logic full;
    rec_t rec;
  } q_stat_t;

  function automatic kind_t mk(input logic [3:0] h, input logic [2:0] l,
                               input logic [1:0] m);
    kind_t k;
    k.hdr   = h;
    k.lenw  = l;
    k.mult  = m;
    k.known = 1'b1;
    return k;
  endfunction

  function automatic kind_t classify(input logic [7:0] id);
    kind_t k;
    unique case (id) inside
      ID_STD_SPEED: k = mk(4'd2, 3'd2, MULT_X1);
      ID_TURBO: k = mk(4'd15, 3'd3, MULT_X1);
      ID_PURE_TONE, ID_STOP_48K: k = mk(4'd4, 3'd0, MULT_X1);
      ID_PULSE_SEQ: k = mk(4'd0, 3'd1, MULT_X2);
      ID_PURE_DATA: k = mk(4'd7, 3'd3, MULT_X1);
      ID_DIRECT_REC: k = mk(4'd5, 3'd3, MULT_X1);
      ID_CSW, ID_GENERALIZED, ID_SET_LEVEL: k = mk(4'd0, 3'd4, MULT_X1);
      ID_PAUSE, ID_JUMP, ID_LOOP_START: k = mk(4'd2, 3'd0, MULT_X1);
      ID_GROUP_START, ID_TEXT: k = mk(4'd0, 3'd1, MULT_X1);
      ID_GROUP_END, ID_LOOP_END, ID_RETURN: k = mk(4'd0, 3'd0, MULT_X1);
      ID_CALL_SEQ: k = mk(4'd0, 3'd2, MULT_X2);
      ID_SELECT, ID_ARCHIVE: k = mk(4'd0, 3'd2, MULT_X1);
      ID_MESSAGE: k = mk(4'd1, 3'd1, MULT_X1);
      ID_HARDWARE: k = mk(4'd0, 3'd1, MULT_X3);
      ID_CUSTOM: k = mk(4'd10, 3'd4, MULT_X1);
      ID_GLUE: k = mk(4'd9, 3'd0, MULT_X1);
      default: begin
        k = mk(4'd0, 3'd4, MULT_X1);
        k.known = 1'b0;
      end
    endcase
    return k;
  endfunction

endpackage

// File: rtl/tibs_byte_if.sv
// ----------------------------------------------------------------------------
// Byte channel interface
// Carries one file byte per word with its end-of-file mark.
// ----------------------------------------------------------------------------
interface tibs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/tibs_block_if.sv
// ----------------------------------------------------------------------------
// Block channel interface
// Carries one framed block description per word.
// ----------------------------------------------------------------------------
interface tibs_block_if;
  import tibs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [7:0]              block_id;
  logic [OFFSET_OUT_W-1:0] block_offset;
  logic [LENGTH_OUT_W-1:0] block_length;
  logic [NUMBER_OUT_W-1:0] block_number;
  logic                    known_type;

  modport source (output valid, output block_id, output block_offset,
                  output block_length, output block_number, output known_type,
                  input ready);
  modport sink (input valid, input block_id, input block_offset,
                input block_length, input block_number, input known_type,
                output ready);
endinterface

// File: rtl/tibs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries the file header skip count.
// ----------------------------------------------------------------------------
interface tibs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_offset;

  modport source (output valid, output start_offset, input ready);
  modport sink (input valid, input start_offset, output ready);
endinterface

// File: rtl/tape_image_block_splitter.sv
// A block record is queued with the byte ending its header, then registered out.
// One byte is accepted every cycle; the byte channel stalls only while the
// two-entry record queue is full, which happens when the block sink holds off.
// Synchronous reset clears the parser, the queue and the output word and sets
// the header skip count to ten; the skip count survives an end of file.
// ----------------------------------------------------------------------------
// Tape image block splitter
// Splits a tape image byte stream into blocks and reports each block's type,
// offset, total length and index.
// ----------------------------------------------------------------------------
module tape_image_block_splitter #(
  parameter int OFFSET_WIDTH = tibs_pkg::OFFSET_WIDTH_DEF,
  parameter int INDEX_WIDTH  = tibs_pkg::INDEX_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tibs_byte_if.sink    bytes,
  tibs_cfg_if.sink     cfg,
  tibs_block_if.source blocks
);
  import tibs_pkg::*;

  logic [7:0] start_offset;
  push_t      push;
  q_stat_t    q;
  logic       pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= START_OFFSET_RST;
    end else if (cfg.valid) begin
      start_offset <= cfg.start_offset;
    end
  end

  tibs_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .start_offset(start_offset),
    .q_full      (q.full),
    .push        (push)
  );

  tibs_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .pop (pop),
    .stat(q)
  );

  tibs_back u_back (
    .clk   (clk),
    .rst   (rst),
    .q     (q),
    .pop   (pop),
    .blocks(blocks)
  );

`ifndef SYNTHESIS
  // The front must never produce a record while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q.full |-> !push.push)
    else $error("record pushed into a full queue");

  // An unknown type always carries a four-byte length field.
  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    (blocks.valid && !blocks.known_type) |-> (blocks.block_length >= 33'd5))
    else $error("unknown block shorter than its length field");

  a_reset_clear: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!blocks.valid && !q.valid))
    else $error("output or queue not empty after reset");
`endif

endmodule

// File: rtl/tibs_front.sv
// ----------------------------------------------------------------------------
// Front parser
// Accepts file bytes, tracks the block structure and queues a record for
// every completed block header.
// ----------------------------------------------------------------------------
module tibs_front #(
  parameter int OFFSET_WIDTH = tibs_pkg::OFFSET_WIDTH_DEF,
  parameter int INDEX_WIDTH  = tibs_pkg::INDEX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  tibs_byte_if.sink       bytes,
  input  logic [7:0]      start_offset,
  input  logic            q_full,
  output tibs_pkg::push_t push
);
  import tibs_pkg::*;

  phase_t                 phase, phase_next, ph;
  logic [OFFSET_WIDTH-1:0] pos, pos_next;
  logic [OFFSET_WIDTH-1:0] block_start, block_start_next;
  logic [7:0]             cur_type, cur_type_next;
  kind_t                  kind_q, kind_q_next;
  logic [4:0]             hdr_cnt, hdr_cnt_next;
  logic [31:0]            acc, acc_next;
  logic [1:0]             lbi, lbi_next;
  logic [PAYLOAD_W-1:0]   pay_rem, pay_rem_next;
  logic [INDEX_WIDTH-1:0] blk_cnt, blk_cnt_next;

  logic                   accept;
  kind_t                  kind_b, kind_r;
  logic [31:0]            acc_full;
  logic [PAYLOAD_W-1:0]   acc_ext, mul;
  logic [4:0]             hdr_inc;
  logic                   emit;
  logic [7:0]             rec_id;
  logic [OFFSET_WIDTH-1:0] rec_off;
  logic [PAYLOAD_W-1:0]   rec_pay;
  logic [OFFSET_WIDTH+OFFSET_OUT_W-1:0] off_wide;
  logic [INDEX_WIDTH+NUMBER_OUT_W-1:0]  num_wide;

  assign bytes.ready = !q_full;
  assign accept = bytes.valid && bytes.ready;

  assign kind_b   = classify(bytes.data_byte);
  assign acc_full = acc | ({24'b0, bytes.data_byte} << {lbi, 3'b000});
  assign acc_ext  = PAYLOAD_W'(acc_full);
  assign hdr_inc  = hdr_cnt + 5'd1;

  always_comb begin
    case (kind_q.mult)
      MULT_X2: mul = acc_ext << 1;
      MULT_X3: mul = acc_ext + (acc_ext << 1);
      default: mul = acc_ext;
    endcase
  end

  always_comb begin
    ph = phase;
    if (phase == PH_SKIP && pos >= OFFSET_WIDTH'(start_offset)) begin
      ph = PH_ID;
    end
    phase_next       = ph;
    pos_next         = pos + 1'b1;
    block_start_next = block_start;
    cur_type_next    = cur_type;
    kind_q_next      = kind_q;
    hdr_cnt_next     = hdr_cnt;
    acc_next         = acc;
    lbi_next         = lbi;
    pay_rem_next     = pay_rem;
    emit             = 1'b0;
    rec_pay          = '0;
    unique case (ph)
      PH_SKIP: begin
      end
      PH_HEADER: begin
        hdr_cnt_next = hdr_inc;
        if (hdr_inc >= {1'b0, kind_q.hdr}) begin
          if (kind_q.lenw != 3'd0) begin
            phase_next = PH_LENGTH;
          end else begin
            emit       = 1'b1;
            phase_next = PH_ID;
          end
        end
      end
      PH_LENGTH: begin
        acc_next = acc_full;
        if ({1'b0, lbi} + 3'd1 >= kind_q.lenw) begin
          pay_rem_next = mul;
          rec_pay      = mul;
          emit         = 1'b1;
          lbi_next     = 2'd0;
          phase_next   = (mul != '0) ? PH_PAYLOAD : PH_ID;
        end else begin
          lbi_next = lbi + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        pay_rem_next = pay_rem - 1'b1;
        if (pay_rem_next == '0) begin
          phase_next = PH_ID;
        end
      end
      default: begin
        cur_type_next    = bytes.data_byte;
        kind_q_next      = kind_b;
        block_start_next = pos;
        hdr_cnt_next     = '0;
        acc_next         = '0;
        lbi_next         = '0;
        pay_rem_next     = '0;
        if (kind_b.hdr != 4'd0) begin
          phase_next = PH_HEADER;
        end else if (kind_b.lenw != 3'd0) begin
          phase_next = PH_LENGTH;
        end else begin
          emit       = 1'b1;
          phase_next = PH_ID;
        end
      end
    endcase
    blk_cnt_next = emit ? blk_cnt + 1'b1 : blk_cnt;
  end

  assign kind_r  = (ph == PH_ID) ? kind_b : kind_q;
  assign rec_id  = (ph == PH_ID) ? bytes.data_byte : cur_type;
  assign rec_off = (ph == PH_ID) ? pos : block_start;
  assign off_wide = {{OFFSET_OUT_W{1'b0}}, rec_off};
  assign num_wide = {{NUMBER_OUT_W{1'b0}}, blk_cnt};

  always_comb begin
    push.push             = accept && emit;
    push.rec.block_id     = rec_id;
    push.rec.block_offset = off_wide[OFFSET_OUT_W-1:0];
    push.rec.payload      = rec_pay;
    push.rec.fixed        = FIXED_W'(5'd1 + 5'(kind_r.hdr) + 5'(kind_r.lenw));
    push.rec.known        = kind_r.known;
    push.rec.block_number = num_wide[NUMBER_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.last_byte)) begin
      phase       <= PH_SKIP;
      pos         <= '0;
      block_start <= '0;
      cur_type    <= '0;
      kind_q      <= '0;
      hdr_cnt     <= '0;
      acc         <= '0;
      lbi         <= '0;
      pay_rem     <= '0;
      blk_cnt     <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      pos         <= pos_next;
      block_start <= block_start_next;
      cur_type    <= cur_type_next;
      kind_q      <= kind_q_next;
      hdr_cnt     <= hdr_cnt_next;
      acc         <= acc_next;
      lbi         <= lbi_next;
      pay_rem     <= pay_rem_next;
      blk_cnt     <= blk_cnt_next;
    end
  end

endmodule

// File: rtl/tibs_queue.sv
// ----------------------------------------------------------------------------
// Record queue
// Short queue of block records between the front parser and the back end.
// ----------------------------------------------------------------------------
module tibs_queue (
  input  logic              clk,
  input  logic              rst,
  input  tibs_pkg::push_t   push,
  input  logic              pop,
  output tibs_pkg::q_stat_t stat
);
  import tibs_pkg::*;

  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC = $clog2(QUEUE_DEPTH + 1);

  rec_t          mem [QUEUE_DEPTH];
  logic [QA-1:0] wr_ptr, rd_ptr;
  logic [QC-1:0] count;
  logic          do_push, do_pop;

  assign do_push = push.push && (count != QC'(QUEUE_DEPTH));
  assign do_pop  = pop && (count != '0);

  assign stat.valid = (count != '0);
  assign stat.full  = (count == QC'(QUEUE_DEPTH));
  assign stat.rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QA'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QA'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tibs_back.sv
// ----------------------------------------------------------------------------
// Back end
// Takes queued records, adds up the total block length and holds the
// result word until the sink takes it.
// ----------------------------------------------------------------------------
module tibs_back (
  input  logic              clk,
  input  logic              rst,
  input  tibs_pkg::q_stat_t q,
  output logic              pop,
  tibs_block_if.source      blocks
);
  import tibs_pkg::*;

  logic                    out_valid;
  logic [7:0]              out_id;
  logic [OFFSET_OUT_W-1:0] out_offset;
  logic [LENGTH_OUT_W-1:0] out_length;
  logic [NUMBER_OUT_W-1:0] out_number;
  logic                    out_known;
  logic [PAYLOAD_W-1:0]    total;

  assign pop   = q.valid && (!out_valid || blocks.ready);
  assign total = q.rec.payload + PAYLOAD_W'(q.rec.fixed);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (blocks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_id     <= q.rec.block_id;
      out_offset <= q.rec.block_offset;
      out_length <= total[LENGTH_OUT_W-1:0];
      out_number <= q.rec.block_number;
      out_known  <= q.rec.known;
    end
  end

  assign blocks.valid        = out_valid;
  assign blocks.block_id     = out_id;
  assign blocks.block_offset = out_offset;
  assign blocks.block_length = out_length;
  assign blocks.block_number = out_number;
  assign blocks.known_type   = out_known;

endmodule
